@@ hw/rtl/prfd_pkg.sv @@
// prfd_pkg: shared types, constants and the ratio window test for the
// pulse ratio frame decoder.
// No dependencies.
package prfd_pkg;

	// Field widths
	localparam int DUR_W    = 16;
	localparam int RATIO_W  = 16;
	localparam int BITS_W   = 7;
	localparam int USED_W   = 8;
	localparam int STATUS_W = 3;
	localparam int VALUE_W  = 64;
	localparam int REG_IDX_W = 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 88;

	// Most data bits one frame can hold
	localparam int MAX_FRAME_BITS = 64;

	// Burst position saturates here
	localparam logic [USED_W-1:0] POS_CAP = 8'd131;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_BIT_RATIO_MIN        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BIT_RATIO_MAX        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_LONG_RATIO_MIN  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_LONG_RATIO_MAX  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_SHORT_RATIO_MIN = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_SHORT_RATIO_MAX = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MIN_FRAME_BITS       = 3'd6;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SYNC   = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_BIT   = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_COUNT     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

	// Parse phase, one-hot
	typedef enum logic [2:0] {
		PH_SYNC = 3'b001,
		PH_DATA = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [RATIO_W-1:0] bit_ratio_min;
		logic [RATIO_W-1:0] bit_ratio_max;
		logic [RATIO_W-1:0] sync_long_ratio_min;
		logic [RATIO_W-1:0] sync_long_ratio_max;
		logic [RATIO_W-1:0] sync_short_ratio_min;
		logic [RATIO_W-1:0] sync_short_ratio_max;
		logic [BITS_W-1:0]  min_frame_bits;
	} cfg_t;

	// Ratio tests on the current duration pair
	typedef struct packed {
		logic sync_ok;
		logic bit_one;
		logic bit_zero;
	} pair_test_t;

	typedef struct packed {
		logic                frame_valid;
		logic [VALUE_W-1:0]  frame_value;
		logic [BITS_W-1:0]   frame_bits;
		logic [USED_W-1:0]   durations_used;
		logic [STATUS_W-1:0] status;
	} result_t;

	// a/b strictly inside (lo, hi), thresholds Q8.8, cross-multiplied
	function automatic logic in_window(
		input logic [DUR_W-1:0]   a,
		input logic [DUR_W-1:0]   b,
		input logic [RATIO_W-1:0] lo,
		input logic [RATIO_W-1:0] hi
	);
		logic [31:0] scaled;
		logic [31:0] lo_prod;
		logic [31:0] hi_prod;
		scaled  = {8'b0, a, 8'b0};
		lo_prod = 32'(lo) * 32'(b);
		hi_prod = 32'(hi) * 32'(b);
		return (scaled > lo_prod) && (scaled < hi_prod);
	endfunction

endpackage

@@ hw/rtl/prfd_cfg_regs.sv @@
// prfd_cfg_regs: threshold and frame length registers of the decoder.
// Depends on prfd_pkg.
module prfd_cfg_regs
	import prfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [RATIO_W-1:0]   wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_ratio_min        <= 16'd384;
			cfg_q.bit_ratio_max        <= 16'd1280;
			cfg_q.sync_long_ratio_min  <= 16'd1536;
			cfg_q.sync_long_ratio_max  <= 16'd3584;
			cfg_q.sync_short_ratio_min <= 16'd5120;
			cfg_q.sync_short_ratio_max <= 16'd10240;
			cfg_q.min_frame_bits       <= 7'd24;
		end else if (wr_en) begin
			case (wr_index)
				REG_BIT_RATIO_MIN:        cfg_q.bit_ratio_min        <= wr_data;
				REG_BIT_RATIO_MAX:        cfg_q.bit_ratio_max        <= wr_data;
				REG_SYNC_LONG_RATIO_MIN:  cfg_q.sync_long_ratio_min  <= wr_data;
				REG_SYNC_LONG_RATIO_MAX:  cfg_q.sync_long_ratio_max  <= wr_data;
				REG_SYNC_SHORT_RATIO_MIN: cfg_q.sync_short_ratio_min <= wr_data;
				REG_SYNC_SHORT_RATIO_MAX: cfg_q.sync_short_ratio_max <= wr_data;
				REG_MIN_FRAME_BITS:       cfg_q.min_frame_bits       <= wr_data[BITS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/prfd_pair_test.sv @@
// prfd_pair_test: sync and data bit ratio tests on one duration pair.
// Depends on prfd_pkg (in_window).
module prfd_pair_test
	import prfd_pkg::*;
(
	input  cfg_t             cfg,
	input  logic [DUR_W-1:0] prev_dur,
	input  logic [DUR_W-1:0] cur_dur,
	output pair_test_t       test
);

	logic sync_long;
	logic sync_short;
	logic one_hit;
	logic zero_hit;

	// Sync: previous over current in either window
	assign sync_long  = in_window(prev_dur, cur_dur,
		cfg.sync_long_ratio_min, cfg.sync_long_ratio_max);
	assign sync_short = in_window(prev_dur, cur_dur,
		cfg.sync_short_ratio_min, cfg.sync_short_ratio_max);

	// Data bit: high/low gives 1, low/high gives 0, the 1 test wins
	assign one_hit  = in_window(prev_dur, cur_dur, cfg.bit_ratio_min, cfg.bit_ratio_max);
	assign zero_hit = in_window(cur_dur, prev_dur, cfg.bit_ratio_min, cfg.bit_ratio_max);

	assign test.sync_ok  = sync_long | sync_short;
	assign test.bit_one  = one_hit;
	assign test.bit_zero = ~one_hit & zero_hit;

endmodule

@@ hw/rtl/prfd_frame_state.sv @@
// prfd_frame_state: per-burst parse state, bit shifter and result build.
// Depends on prfd_pkg.
module prfd_frame_state
	import prfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [DUR_W-1:0]  dur,
	input  logic              last,
	input  pair_test_t        test,
	input  logic [BITS_W-1:0] min_frame_bits,
	output logic [DUR_W-1:0]  prev_dur,
	output result_t           result
);

	phase_t              phase_q, phase_n;
	logic [DUR_W-1:0]    prev_q;
	logic [USED_W-1:0]   pos_q;
	logic [BITS_W-1:0]   bits_q, bits_n;
	logic [VALUE_W-1:0]  value_q, value_n;
	logic [STATUS_W-1:0] status_q, status_n;
	logic [USED_W-1:0]   used_q, used_n;
	logic                count_ok_cur;
	logic                count_ok_new;
	logic                pair_pos;

	assign prev_dur = prev_q;

	// Count rule: enough bits and an even number of them
	assign count_ok_cur = (bits_q >= min_frame_bits) && !bits_q[0];
	assign count_ok_new = (bits_n >= min_frame_bits) && !bits_n[0];
	assign pair_pos     = (pos_q != '0) && !pos_q[0];

	// Parse step for the current item
	always_comb begin
		phase_n  = phase_q;
		bits_n   = bits_q;
		value_n  = value_q;
		status_n = status_q;
		used_n   = used_q;
		case (phase_q)
			PH_SYNC: begin
				if (pos_q == 8'd1) begin
					if (test.sync_ok) begin
						phase_n = PH_DATA;
					end else begin
						phase_n  = PH_DONE;
						status_n = STATUS_NO_SYNC;
						used_n   = '0;
					end
				end else if (last) begin
					phase_n  = PH_DONE;
					status_n = STATUS_NO_SYNC;
					used_n   = '0;
				end
			end
			PH_DATA: begin
				if (pair_pos) begin
					if (test.bit_one || test.bit_zero) begin
						if (bits_q >= BITS_W'(MAX_FRAME_BITS)) begin
							phase_n  = PH_DONE;
							status_n = STATUS_OVERFLOW;
							used_n   = '0;
						end else begin
							value_n = {value_q[VALUE_W-2:0], test.bit_one};
							bits_n  = bits_q + 7'd1;
						end
					end else if (count_ok_cur) begin
						phase_n  = PH_DONE;
						status_n = STATUS_OK;
						used_n   = pos_q;
					end else begin
						phase_n  = PH_DONE;
						status_n = STATUS_BAD_BIT;
						used_n   = '0;
					end
				end
			end
			default: begin
			end
		endcase
		// Burst ends while data is still being read
		if (last && phase_n == PH_DATA) begin
			phase_n = PH_DONE;
			if (count_ok_new) begin
				status_n = STATUS_OK;
				used_n   = pos_q + 8'd1;
			end else begin
				status_n = STATUS_COUNT;
				used_n   = '0;
			end
		end
	end

	// Result for a burst_end item
	always_comb begin
		result = '0;
		if (phase_n == PH_DONE && status_n == STATUS_OK) begin
			result.frame_valid    = 1'b1;
			result.frame_value    = value_n;
			result.frame_bits     = bits_n;
			result.durations_used = used_n;
		end else begin
			result.status = status_n;
		end
	end

	// State update; a burst end returns everything to the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC;
			prev_q   <= '0;
			pos_q    <= '0;
			bits_q   <= '0;
			value_q  <= '0;
			status_q <= STATUS_OK;
			used_q   <= '0;
		end else if (step) begin
			if (last) begin
				phase_q  <= PH_SYNC;
				prev_q   <= '0;
				pos_q    <= '0;
				bits_q   <= '0;
				value_q  <= '0;
				status_q <= STATUS_OK;
				used_q   <= '0;
			end else begin
				phase_q  <= phase_n;
				prev_q   <= dur;
				bits_q   <= bits_n;
				value_q  <= value_n;
				status_q <= status_n;
				used_q   <= used_n;
				if (pos_q < POS_CAP) begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/pulse_ratio_frame_decoder.sv @@
// pulse_ratio_frame_decoder: top level with input register, result register
// and configuration port. Depends on prfd_pkg, prfd_cfg_regs,
// prfd_pair_test and prfd_frame_state.

// Decodes bursts of pulse durations into frames of up to 64 bits. One
// duration is taken per cycle; each is registered, tested against the sync
// and bit ratio windows (eight 16x16 cross-multiply compares) and folded into
// the burst state as it leaves the input register; the result for a burst is
// then held in the result register and offered on the master side. Only a
// burst_end item can stall, and only while the previous result still sits in
// the output register untaken. The cfg channel is always ready; the user must write
// configuration through it only while the block is idle, which the block does not enforce.
module pulse_ratio_frame_decoder
	import prfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input durations
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] duration
	input  logic                  s_tlast,   // burst_end
	// Frame results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] frame_value, [70:64] frame_bits,
	                                         // [78:71] durations_used, [81:79] status
	output logic                  m_tuser,   // frame_valid
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [RATIO_W-1:0]    cfg_data
);

	cfg_t             cfg;
	pair_test_t       test;
	result_t          result;
	result_t          result_q;
	logic             valid_s1;
	logic [DUR_W-1:0] dur_s1;
	logic             last_s1;
	logic             m_valid_q;
	logic [DUR_W-1:0] prev_dur;
	logic             step;

	assign cfg_ready = 1'b1;

	prfd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Item in stage 1 moves on unless it needs a full result register
	assign step     = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			dur_s1  <= s_tdata[DUR_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	prfd_pair_test u_test (
		.cfg      (cfg),
		.prev_dur (prev_dur),
		.cur_dur  (dur_s1),
		.test     (test)
	);

	prfd_frame_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.dur            (dur_s1),
		.last           (last_s1),
		.test           (test),
		.min_frame_bits (cfg.min_frame_bits),
		.prev_dur       (prev_dur),
		.result         (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = result_q.frame_valid;
	assign m_tdata  = {6'b0, result_q.status, result_q.durations_used,
		result_q.frame_bits, result_q.frame_value};

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives bursts of pulse durations into pulse_ratio_frame_decoder and
// checks every frame result, field by field, against a predictor kept in a scoreboard.
// Depends on prfd_pkg and the decoder RTL.
module testbench;
	import prfd_pkg::*;

	// Predicts frame results from accepted items and checks the block's results
	class frame_tracker;
		cfg_t                regs;
		logic [DUR_W-1:0]    last_dur;
		logic [USED_W-1:0]   pos;
		logic [BITS_W-1:0]   nbits;
		logic [VALUE_W-1:0]  bits_acc;
		phase_t              phase;
		logic [STATUS_W-1:0] held_status;
		logic [USED_W-1:0]   held_used;
		result_t             frames_due[$];
		int                  errors;
		int                  items_taken;

		function new();
			regs.bit_ratio_min        = 16'd384;
			regs.bit_ratio_max        = 16'd1280;
			regs.sync_long_ratio_min  = 16'd1536;
			regs.sync_long_ratio_max  = 16'd3584;
			regs.sync_short_ratio_min = 16'd5120;
			regs.sync_short_ratio_max = 16'd10240;
			regs.min_frame_bits       = 7'd24;
			errors      = 0;
			items_taken = 0;
			restart_burst();
		endfunction

		function void restart_burst();
			last_dur    = '0;
			pos         = '0;
			nbits       = '0;
			bits_acc    = '0;
			phase       = PH_SYNC;
			held_status = STATUS_OK;
			held_used   = '0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
			case (idx)
				REG_BIT_RATIO_MIN:        regs.bit_ratio_min = val;
				REG_BIT_RATIO_MAX:        regs.bit_ratio_max = val;
				REG_SYNC_LONG_RATIO_MIN:  regs.sync_long_ratio_min = val;
				REG_SYNC_LONG_RATIO_MAX:  regs.sync_long_ratio_max = val;
				REG_SYNC_SHORT_RATIO_MIN: regs.sync_short_ratio_min = val;
				REG_SYNC_SHORT_RATIO_MAX: regs.sync_short_ratio_max = val;
				REG_MIN_FRAME_BITS:       regs.min_frame_bits = val[BITS_W-1:0];
				default: ;
			endcase
		endfunction

		// a/b strictly between lo and hi (Q8.8), exact in 64 bits
		function bit ratio_inside(logic [DUR_W-1:0] a, logic [DUR_W-1:0] b,
			logic [RATIO_W-1:0] lo, logic [RATIO_W-1:0] hi);
			longint unsigned num, den, lo_l, hi_l;
			num  = 64'(a);
			num  = num << 8;
			den  = 64'(b);
			lo_l = 64'(lo);
			hi_l = 64'(hi);
			return (num > lo_l * den) && (num < hi_l * den);
		endfunction

		function bit count_ok();
			return (nbits >= regs.min_frame_bits) && (nbits[0] == 1'b0);
		endfunction

		function void settle(logic [STATUS_W-1:0] st, logic [USED_W-1:0] used);
			phase       = PH_DONE;
			held_status = st;
			held_used   = used;
		endfunction

		function void note_item(logic [DUR_W-1:0] dur, logic last);
			logic    one_bit;
			logic    zero_bit;
			result_t res;
			items_taken++;
			if (phase == PH_SYNC) begin
				if (pos == 8'd1) begin
					if (ratio_inside(last_dur, dur, regs.sync_long_ratio_min,
							regs.sync_long_ratio_max) ||
						ratio_inside(last_dur, dur, regs.sync_short_ratio_min,
							regs.sync_short_ratio_max))
						phase = PH_DATA;
					else
						settle(STATUS_NO_SYNC, '0);
				end else if (last) begin
					settle(STATUS_NO_SYNC, '0);
				end
			end else if (phase == PH_DATA && pos >= 8'd2 && !pos[0]) begin
				// pair (previous, current): long/short is a one, short/long a zero
				one_bit  = ratio_inside(last_dur, dur, regs.bit_ratio_min, regs.bit_ratio_max);
				zero_bit = !one_bit &&
					ratio_inside(dur, last_dur, regs.bit_ratio_min, regs.bit_ratio_max);
				if (one_bit || zero_bit) begin
					if (nbits >= MAX_FRAME_BITS) begin
						settle(STATUS_OVERFLOW, '0);
					end else begin
						bits_acc = {bits_acc[VALUE_W-2:0], one_bit};
						nbits++;
					end
				end else if (count_ok()) begin
					settle(STATUS_OK, pos);
				end else begin
					settle(STATUS_BAD_BIT, '0);
				end
			end
			if (last && phase == PH_DATA) begin
				if (count_ok())
					settle(STATUS_OK, pos + 8'd1);
				else
					settle(STATUS_COUNT, '0);
			end
			last_dur = dur;
			if (!last) begin
				if (pos < POS_CAP)
					pos++;
			end else begin
				res = '0;
				if (held_status == STATUS_OK && phase == PH_DONE) begin
					res.frame_valid    = 1'b1;
					res.frame_value    = bits_acc;
					res.frame_bits     = nbits;
					res.durations_used = held_used;
				end
				res.status = held_status;
				frames_due.push_back(res);
				restart_burst();
			end
		endfunction

		function void check_frame(logic valid, logic [OUT_DATA_W-1:0] data);
			result_t want;
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected frame result: valid=%0b data=%h", valid, data);
				return;
			end
			want = frames_due.pop_front();
			if (valid !== want.frame_valid || data[63:0] !== want.frame_value ||
				data[70:64] !== want.frame_bits || data[78:71] !== want.durations_used ||
				data[81:79] !== want.status) begin
				errors++;
				if (errors <= 10) begin
					$display("frame mismatch: expected valid=%0b value=%h bits=%0d used=%0d st=%0d",
						want.frame_valid, want.frame_value, want.frame_bits,
						want.durations_used, want.status);
					$display("                got      valid=%0b value=%h bits=%0d used=%0d st=%0d",
						valid, data[63:0], data[70:64], data[78:71], data[81:79]);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [RATIO_W-1:0]    cfg_data;

	frame_tracker tracker = new();
	bit           all_calm;
	int           hold_req;

	pulse_ratio_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one duration item, optionally after a random gap, and wait for it to be taken
	task automatic send_item(input logic [DUR_W-1:0] dur, input logic last, input bit calm);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= dur;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_item(dur, last);
	endtask

	// One register write; cfg_valid stays up for back-to-back writes
	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	task automatic load_regs(input logic [15:0] bit_lo, input logic [15:0] bit_hi,
		input logic [15:0] long_lo, input logic [15:0] long_hi,
		input logic [15:0] short_lo, input logic [15:0] short_hi,
		input logic [15:0] frame_min);
		put_reg(REG_BIT_RATIO_MIN, bit_lo);
		put_reg(REG_BIT_RATIO_MAX, bit_hi);
		put_reg(REG_SYNC_LONG_RATIO_MIN, long_lo);
		put_reg(REG_SYNC_LONG_RATIO_MAX, long_hi);
		put_reg(REG_SYNC_SHORT_RATIO_MIN, short_lo);
		put_reg(REG_SYNC_SHORT_RATIO_MAX, short_hi);
		put_reg(REG_MIN_FRAME_BITS, frame_min);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and let every pending frame come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.frames_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// x scaled by the middle of the (lo, hi) window, saturated to 16 bits
	function automatic logic [15:0] stretch(input logic [15:0] x, input logic [15:0] lo,
		input logic [15:0] hi);
		longint unsigned xl, p;
		xl = 64'(x);
		p  = 64'(lo);
		p  = (xl * (p + 64'(hi))) / 512;
		return (p > 65535) ? 16'hFFFF : p[15:0];
	endfunction

	// One random burst: mostly well-formed frames, some broken ones, some noise
	task automatic send_random_burst();
		logic [DUR_W-1:0] durs[$];
		logic [DUR_W-1:0] s, l, lead;
		longint unsigned  cap;
		int               kind, nbits, lo_n, hi_n, mfb, smax;
		bit               calm;
		kind = $urandom_range(0, 99);
		calm = all_calm || ($urandom_range(0, 3) == 0);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8)) durs.push_back(16'($urandom_range(0, 65535)));
		end else if (kind < 15) begin
			durs.push_back(16'($urandom_range(0, 65535)));
		end else begin
			mfb = int'(tracker.regs.min_frame_bits);
			if (kind < 22) begin
				nbits = $urandom_range(65, 67);
			end else begin
				hi_n  = (mfb + 8 > 64) ? 64 : mfb + 8;
				lo_n  = (mfb > 6) ? mfb - 6 : 0;
				lo_n  = (lo_n > hi_n) ? hi_n - 6 : lo_n;
				nbits = $urandom_range(lo_n, hi_n);
			end
			cap  = 64'(65535 * 512);
			cap  = cap / (longint'(tracker.regs.bit_ratio_min) +
				longint'(tracker.regs.bit_ratio_max) + 1);
			smax = (cap > 400) ? 400 : ((cap < 1) ? 1 : int'(cap));
			for (int k = 0; k < nbits; k++) begin
				s = (k == 0) ? 16'($urandom_range(1, 20)) : 16'($urandom_range(1, smax));
				l = stretch(s, tracker.regs.bit_ratio_min, tracker.regs.bit_ratio_max);
				if ($urandom_range(0, 1)) begin
					durs.push_back(l);
					durs.push_back(s);
				end else begin
					durs.push_back(s);
					durs.push_back(l);
				end
			end
			if (nbits == 0)
				durs.push_back(16'($urandom_range(1, 60)));
			// sync lead from either window
			if ($urandom_range(0, 1))
				lead = stretch(durs[0], tracker.regs.sync_long_ratio_min,
					tracker.regs.sync_long_ratio_max);
			else
				lead = stretch(durs[0], tracker.regs.sync_short_ratio_min,
					tracker.regs.sync_short_ratio_max);
			durs.push_front(lead);
			case ($urandom_range(0, 2))
				1: begin
					// equal pair ends the frame, trailing items ignored
					s = 16'($urandom_range(1, 1000));
					durs.push_back(s);
					durs.push_back(s);
					repeat ($urandom_range(0, 3))
						durs.push_back(16'($urandom_range(0, 65535)));
				end
				2: durs.push_back(16'($urandom_range(0, 65535)));
				default: ;
			endcase
			if (kind < 27)
				durs[$urandom_range(0, durs.size() - 1)] = 16'($urandom_range(0, 65535));
		end
		foreach (durs[i])
			send_item(durs[i], i == durs.size() - 1, calm);
	endtask

	task automatic run_bursts(input int budget);
		int start;
		start = tracker.items_taken;
		while (tracker.items_taken - start < budget)
			send_random_burst();
		wait_idle();
	endtask

	// Result side: random stall per result, long hold-off on request
	initial begin : result_sink
		int wait_left;
		wait_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				tracker.check_frame(m_tuser, m_tdata);
				wait_left = all_calm ? 0 : $urandom_range(0, 12);
			end
			if (hold_req > 0) begin
				wait_left = hold_req;
				hold_req  = 0;
			end
			if (wait_left > 0) begin
				m_tready <= 1'b0;
				wait_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		all_calm  = 1'b0;
		hold_req  = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default windows, two-bit frames allowed
		load_regs(16'd384, 16'd1280, 16'd1536, 16'd3584, 16'd5120, 16'd10240, 16'd2);
		// lone items at both extremes
		send_item(16'd0, 1'b1, 1'b0);
		send_item(16'hFFFF, 1'b1, 1'b0);
		// zero divisor in the sync pair, later item ignored
		send_item(16'd1000, 1'b0, 1'b0);
		send_item(16'd0, 1'b0, 1'b0);
		send_item(16'd5, 1'b1, 1'b0);
		// long sync, one zero bit, odd count at burst end
		send_item(16'd800, 1'b0, 1'b0);
		send_item(16'd100, 1'b0, 1'b0);
		send_item(16'd300, 1'b1, 1'b0);
		// short sync, two one bits, valid at burst end
		send_item(16'd3000, 1'b0, 1'b0);
		send_item(16'd100, 1'b0, 1'b0);
		send_item(16'd30, 1'b0, 1'b0);
		send_item(16'd100, 1'b0, 1'b0);
		send_item(16'd40, 1'b1, 1'b0);
		// valid frame ended by an unmatched pair, trailing item ignored
		send_item(16'd800, 1'b0, 1'b0);
		send_item(16'd100, 1'b0, 1'b0);
		send_item(16'd300, 1'b0, 1'b0);
		send_item(16'd200, 1'b0, 1'b0);
		send_item(16'd50, 1'b0, 1'b0);
		send_item(16'd100, 1'b0, 1'b0);
		send_item(16'd100, 1'b0, 1'b0);
		send_item(16'hFFFF, 1'b1, 1'b0);
		// sync ratio exactly on the lower bound fails
		send_item(16'd600, 1'b0, 1'b0);
		send_item(16'd100, 1'b1, 1'b0);
		wait_idle();

		// Random phases over several settings
		load_regs(16'd384, 16'd1280, 16'd1536, 16'd3584, 16'd5120, 16'd10240, 16'd24);
		run_bursts(250);
		load_regs(16'd384, 16'd1280, 16'd1536, 16'd3584, 16'd5120, 16'd10240, 16'd8);
		run_bursts(300);
		load_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		run_bursts(150);
		all_calm = 1'b1;
		load_regs(16'($urandom_range(256, 600)), 16'($urandom_range(900, 2600)),
			16'($urandom_range(600, 1500)), 16'($urandom_range(2000, 4500)),
			16'($urandom_range(4600, 6000)), 16'($urandom_range(7000, 12000)),
			16'($urandom_range(0, 32)));
		run_bursts(300);
		all_calm = 1'b0;
		load_regs(16'd384, 16'd1280, 16'd1536, 16'd3584, 16'd5120, 16'd10240, 16'd64);
		run_bursts(200);
		// empty bit window, empty second sync window, min bits beyond range
		load_regs(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		run_bursts(100);
		// long receiver hold-off while short frames keep coming
		load_regs(16'd384, 16'd1280, 16'd1536, 16'd3584, 16'd5120, 16'd10240, 16'd4);
		hold_req = 400;
		run_bursts(150);

		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.frames_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
